FILE: rtl/tpc_pkg.sv
// Shared constants, codes and state type of the three-axis PID controller.
package tpc_pkg;

  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int EXT_AXES  = 2;

  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // shared multiplier: unsigned A times signed B
  localparam int MA_W   = 20;
  localparam int MB_W   = 38;
  localparam int PROD_W = 59;
  localparam int SUM_W  = 64;

  // shared restoring divider
  localparam int DW     = 42;
  localparam int DEN_W  = 20;
  localparam int CNT_W  = 6;

  localparam logic [DEN_W-1:0] US_PER_S = 20'd1000000;

  // integrator step: e*dt*256/1e6 = e*dt*4/15625, multiplied by ceil(2^47/15625)
  // split at bit 17 into two multiplier passes; the bias does the rounding
  localparam logic [MA_W-1:0] RCP_LO   = 20'd62487;
  localparam logic [MA_W-1:0] RCP_HI   = 20'd68719;
  localparam logic [DW-1:0]   RCP_BIAS = 42'd7812;

  typedef enum logic [1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_CLR_INT = 2'd1,
    REQ_CLR_ALL = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GAINS_ROLL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAINS_PITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAINS_YAW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP  = 3'd4;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_EDT   = 12'b0000_0000_0010,
    S_DIVI  = 12'b0000_0000_0100,
    S_RUNI  = 12'b0000_0000_1000,
    S_CLAMP = 12'b0000_0001_0000,
    S_DIVD  = 12'b0000_0010_0000,
    S_RUND  = 12'b0000_0100_0000,
    S_KP    = 12'b0000_1000_0000,
    S_KI    = 12'b0001_0000_0000,
    S_KD    = 12'b0010_0000_0000,
    S_SUM   = 12'b0100_0000_0000,
    S_RND   = 12'b1000_0000_0000
  } state_t;

endpackage

FILE: rtl/three_axis_pid_controller_top.sv
// Three-axis PID controller with one shared multiplier and one shared divider.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready   | in_tdata setpoints, measures, rates, dt
//  out_    | out | out_tvalid/out_tready | out_tdata drive roll, pitch, yaw
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An update runs the axes in turn: a reciprocal multiply for the integrator
// step, a divider run for the derivative, then the multiply-accumulate steps.
// Roll and pitch skip the derivative divide when the external rate
// replaces it. Clear requests are handled in the idle state and start no update.
// Reset is synchronous, active low, and clears gains, limits, integrators and
// derivative history. The input waits while an update is in flight; a result
// waits in the output register and stalls only the final write of the next one.
module three_axis_pid_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // setpoint_roll, setpoint_pitch, setpoint_yaw, measured_roll, measured_pitch,
  // measured_yaw, ext_rate_roll, ext_rate_pitch, elapsed_us
  input  logic [tpc_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type, use_ext_rate
  input  logic [tpc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drive_roll, drive_pitch, drive_yaw
  output logic [tpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tpc_pkg::*;

  state_t state_r, state_nxt;
  logic [AXIS_W-1:0]       axis_r;
  logic [15:0]             dt_r;
  logic                    use_ext_r;
  logic signed [15:0]      sp_r   [NUM_AXES];
  logic signed [15:0]      pv_r   [NUM_AXES];
  logic signed [15:0]      ext_r  [EXT_AXES];
  logic [47:0]             gains_r [NUM_AXES];
  logic [30:0]             lim_r;
  logic [15:0]             fixed_r;
  logic signed [31:0]      integ_r [NUM_AXES];
  logic signed [15:0]      last_r  [NUM_AXES];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [31:0]      acc_r;
  logic signed [MB_W-1:0]  d_r;
  logic [DEN_W-1:0]        rem_r;
  logic [DW-1:0]           quo_r;
  logic [DEN_W-1:0]        den_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic signed [31:0]      drv_r [NUM_AXES];
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic                    in_acc;
  req_t                    req;
  logic [15:0]             dt_sel;
  logic signed [16:0]      e_c, dpv_c;
  logic [15:0]             kp_c, ki_c, kd_c;
  logic [MA_W-1:0]         mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] ma_x, mb_x, mul_p;
  logic [PROD_W-1:0]       prod_abs;
  logic [DW-1:0]           num_c, num_rnd;
  logic [DEN_W-1:0]        den_c;
  logic [DEN_W:0]          trial;
  logic                    ge;
  logic [DW-1:0]           quo_nxt;
  logic [DEN_W-1:0]        rem_nxt;
  logic                    div_done;
  logic [DW-1:0]           m_c;
  logic [PROD_W-1:0]       rcp_sum;
  logic                    rcp_done;
  logic signed [33:0]      qi_s, acc_sum, lim_s, acc_cl;
  logic signed [MB_W-1:0]  qd_s;
  logic signed [SUM_W-1:0] prod_x, prod_x8;
  logic [SUM_W-1:0]        sum_abs;
  logic [SUM_W-13:0]       rq;
  logic signed [31:0]      drive_c;
  logic                    last_axis, out_free, out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign req        = req_t'(in_tuser[1:0]);
  assign dt_sel     = (fixed_r != 16'd0) ? fixed_r : in_tdata[143:128];

  assign e_c   = {sp_r[axis_r][15], sp_r[axis_r]} - {pv_r[axis_r][15], pv_r[axis_r]};
  assign dpv_c = {pv_r[axis_r][15], pv_r[axis_r]} - {last_r[axis_r][15], last_r[axis_r]};
  assign kp_c  = gains_r[axis_r][15:0];
  assign ki_c  = gains_r[axis_r][31:16];
  assign kd_c  = gains_r[axis_r][47:32];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EDT:   begin mul_a = {4'd0, dt_r}; mul_b = MB_W'(e_c);   end
      S_RUNI:  begin
        mul_a = (cnt_r == '0) ? RCP_LO : RCP_HI;
        mul_b = {{(MB_W-34){1'b0}}, quo_r[33:0]};
      end
      S_CLAMP: begin mul_a = US_PER_S;     mul_b = MB_W'(dpv_c); end
      S_KP:    begin mul_a = {4'd0, kp_c}; mul_b = MB_W'(e_c);   end
      S_KI:    begin mul_a = {4'd0, ki_c}; mul_b = MB_W'(acc_r); end
      S_KD:    begin mul_a = {4'd0, kd_c}; mul_b = d_r;          end
      default: begin mul_a = '0;           mul_b = '0;           end
    endcase
  end

  assign ma_x  = {{(PROD_W-MA_W){1'b0}}, mul_a};
  assign mb_x  = {{(PROD_W-MB_W){mul_b[MB_W-1]}}, mul_b};
  assign mul_p = ma_x * mb_x;

  // divider operands: magnitude plus half the divisor for round-half-away
  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign den_c    = {4'd0, dt_r};
  assign num_c    = prod_abs[DW-1:0];
  assign num_rnd  = num_c + {{(DW-DEN_W){1'b0}}, (den_c >> 1)};

  // integrator step: (4*|e*dt| + bias) times the reciprocal, upper and lower halves
  assign m_c      = {{(DW-34){1'b0}}, prod_abs[31:0], 2'b00} + RCP_BIAS;
  assign rcp_sum  = $unsigned(prod_r) + {{(PROD_W-DW){1'b0}}, quo_r};
  assign rcp_done = (cnt_r == CNT_W'(2));

  assign trial    = {rem_r, quo_r[DW-1]};
  assign ge       = (trial >= {1'b0, den_r});
  assign rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
  assign quo_nxt  = {quo_r[DW-2:0], ge};
  assign div_done = (cnt_r == CNT_W'(DW - 1));

  // integrator add and clamp
  assign qi_s    = neg_r ? -$signed({1'b0, quo_r[32:0]}) : $signed({1'b0, quo_r[32:0]});
  assign acc_sum = {{2{integ_r[axis_r][31]}}, integ_r[axis_r]} + qi_s;
  assign lim_s   = {3'd0, lim_r};
  always_comb begin
    priority if (acc_sum > lim_s) acc_cl = lim_s;
    else if (acc_sum < -lim_s)    acc_cl = -lim_s;
    else                          acc_cl = acc_sum;
  end

  assign qd_s = neg_r ? -$signed({1'b0, quo_nxt[MB_W-2:0]})
                      :  $signed({1'b0, quo_nxt[MB_W-2:0]});

  assign prod_x  = {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign prod_x8 = {prod_x[SUM_W-9:0], 8'd0};

  // round by 4096 and saturate
  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rq      = (SUM_W-12)'((sum_abs + SUM_W'(2048)) >> 12);
  always_comb begin
    if (sum_r[SUM_W-1]) begin
      drive_c = (rq > (SUM_W-12)'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(rq[31:0]);
    end else begin
      drive_c = (rq > (SUM_W-12)'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(rq[31:0]);
    end
  end

  assign last_axis = (axis_r == AXIS_W'(NUM_AXES - 1));
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_RND) && last_axis && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && req == REQ_UPDATE) state_nxt = S_EDT;
      S_EDT:   state_nxt = S_DIVI;
      S_DIVI:  state_nxt = S_RUNI;
      S_RUNI:  if (rcp_done) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = (use_ext_r && axis_r < AXIS_W'(EXT_AXES)) ? S_KP : S_DIVD;
      S_DIVD:  state_nxt = S_RUND;
      S_RUND:  if (div_done) state_nxt = S_KP;
      S_KP:    state_nxt = S_KI;
      S_KI:    state_nxt = S_KD;
      S_KD:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_RND;
      S_RND: begin
        if (!last_axis)    state_nxt = S_EDT;
        else if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      axis_r       <= '0;
      out_tvalid_r <= 1'b0;
      lim_r        <= '0;
      fixed_r      <= '0;
      cnt_r        <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        gains_r[i] <= '0;
        integ_r[i] <= '0;
        last_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GAINS_ROLL:  gains_r[0] <= cfg_data;
          CFG_GAINS_PITCH: gains_r[1] <= cfg_data;
          CFG_GAINS_YAW:   gains_r[2] <= cfg_data;
          CFG_INT_LIMIT:   lim_r      <= cfg_data[30:0];
          CFG_FIXED_STEP:  fixed_r    <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            axis_r    <= '0;
            use_ext_r <= in_tuser[2];
            dt_r      <= (dt_sel == 16'd0) ? 16'd1 : dt_sel;
            for (int i = 0; i < NUM_AXES; i++) begin
              sp_r[i] <= in_tdata[16*i +: 16];
              pv_r[i] <= in_tdata[48 + 16*i +: 16];
            end
            for (int i = 0; i < EXT_AXES; i++) ext_r[i] <= in_tdata[96 + 16*i +: 16];
            unique case (req)
              REQ_CLR_INT: for (int i = 0; i < NUM_AXES; i++) integ_r[i] <= '0;
              REQ_CLR_ALL: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                  integ_r[i] <= '0;
                  last_r[i]  <= '0;
                end
              end
              REQ_UPDATE, REQ_NONE: ;
            endcase
          end
        end
        S_EDT: prod_r <= mul_p;
        S_DIVI: begin
          quo_r <= m_c;
          neg_r <= prod_r[PROD_W-1];
          cnt_r <= '0;
        end
        S_DIVD: begin
          quo_r <= num_rnd;
          rem_r <= '0;
          den_r <= den_c;
          neg_r <= prod_r[PROD_W-1];
          cnt_r <= '0;
        end
        S_RUNI: begin
          cnt_r <= cnt_r + CNT_W'(1);
          // low half product, then high half with the low half shifted down, then sum
          if (cnt_r == '0) begin
            prod_r <= mul_p;
          end else if (!rcp_done) begin
            prod_r <= mul_p;
            quo_r  <= prod_r[PROD_W-1:PROD_W-DW];
          end else begin
            quo_r  <= DW'(rcp_sum[PROD_W-1:30]);
          end
        end
        S_CLAMP: begin
          acc_r           <= acc_cl[31:0];
          integ_r[axis_r] <= acc_cl[31:0];
          prod_r          <= mul_p;
          if (axis_r < AXIS_W'(EXT_AXES)) d_r <= MB_W'(ext_r[axis_r[0]]);
        end
        S_RUND: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (div_done) begin
            d_r            <= qd_s;
            last_r[axis_r] <= pv_r[axis_r];
          end
        end
        S_KP: prod_r <= mul_p;
        S_KI: begin
          sum_r  <= prod_x8;
          prod_r <= mul_p;
        end
        S_KD: begin
          sum_r  <= sum_r + prod_x;
          prod_r <= mul_p;
        end
        S_SUM: sum_r <= sum_r - prod_x8;
        S_RND: begin
          if (!last_axis) begin
            drv_r[axis_r] <= drive_c;
            axis_r        <= axis_r + AXIS_W'(1);
          end else if (out_free) begin
            // hold until the previous result is taken
            out_tdata_r  <= {drive_c, drv_r[1], drv_r[0]};
          end
        end
        default: ;
      endcase
    end
  end

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUNI || state_r == S_RUND) |-> cnt_r < CNT_W'(DW))
    else $error("divider ran past its last step");

  a_dt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> dt_r != 16'd0)
    else $error("step time is zero during an update");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLAMP) |-> (acc_cl <= lim_s) && (acc_cl >= -lim_s))
    else $error("integrator outside its limit");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && last_axis && out_tvalid_r && !out_tready) |=> state_r == S_RND)
    else $error("result overwrote an untaken transaction");

endmodule

FILE: verif/tpc_checker.sv
// Checker for the three-axis PID controller: predicts drives and compares results.
module tpc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tpc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [tpc_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               drives_seen
);
  import tpc_pkg::*;

  logic [47:0]        gain_word [3];
  logic [30:0]        clamp_mag;
  logic [15:0]        step_fixed;
  logic signed [31:0] integ [3];
  logic signed [15:0] prev_meas [3];
  logic [OUT_DATA_W-1:0] drive_q [$];

  function automatic longint round_div(longint num, longint den);
    longint m;
    longint q;
    m = num < 0 ? -num : num;
    q = (m + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  task automatic predict_update(input logic [IN_DATA_W-1:0] d, input logic ext);
    longint dt, sp, pv, e, acc, lim, rate, kp, ki, kd, sum, drv;
    logic [OUT_DATA_W-1:0] word;
    dt = step_fixed != 0 ? longint'(step_fixed) : longint'(d[128 +: 16]);
    if (dt == 0) dt = 1;
    lim = longint'(clamp_mag);
    for (int a = 0; a < 3; a++) begin
      sp = longint'($signed(d[16*a +: 16]));
      pv = longint'($signed(d[48 + 16*a +: 16]));
      e = sp - pv;
      acc = longint'(integ[a]) + round_div(e * dt * 256, 1000000);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integ[a] = acc[31:0];
      if (ext && a < EXT_AXES) begin
        rate = longint'($signed(d[96 + 16*a +: 16]));
      end else begin
        rate = round_div((pv - longint'(prev_meas[a])) * 1000000, dt);
        prev_meas[a] = pv[15:0];
      end
      kp = longint'(gain_word[a][15:0]);
      ki = longint'(gain_word[a][31:16]);
      kd = longint'(gain_word[a][47:32]);
      sum = kp * e * 256 + ki * acc - kd * rate * 256;
      drv = round_div(sum, 4096);
      if (drv > 64'sd2147483647) drv = 64'sd2147483647;
      if (drv < -64'sd2147483648) drv = -64'sd2147483648;
      word[32*a +: 32] = drv[31:0];
    end
    drive_q.push_back(word);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        gain_word[a] <= '0;
        integ[a] = '0;
        prev_meas[a] = '0;
      end
      clamp_mag <= '0;
      step_fixed <= '0;
      fail_count <= 0;
      drives_seen <= 0;
      pending <= drive_q.size();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAINS_ROLL:  gain_word[0] <= cfg_data;
          CFG_GAINS_PITCH: gain_word[1] <= cfg_data;
          CFG_GAINS_YAW:   gain_word[2] <= cfg_data;
          CFG_INT_LIMIT:   clamp_mag <= cfg_data[30:0];
          CFG_FIXED_STEP:  step_fixed <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (req_t'(in_tuser[1:0]))
          REQ_UPDATE: predict_update(in_tdata, in_tuser[2]);
          REQ_CLR_INT, REQ_CLR_ALL: begin
            for (int a = 0; a < 3; a++) begin
              integ[a] = '0;
              if (in_tuser[1:0] == REQ_CLR_ALL) prev_meas[a] = '0;
            end
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        drives_seen <= drives_seen + 1;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          for (int a = 0; a < 3; a++)
            if (drive_q[0][32*a +: 32] !== out_tdata[32*a +: 32])
              $display("%0t: axis %0d drive expected %h actual %h", $time, a,
                       drive_q[0][32*a +: 32], out_tdata[32*a +: 32]);
          if (drive_q[0] !== out_tdata) fail_count <= fail_count + 1;
          void'(drive_q.pop_front());
        end
      end
      pending <= drive_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// Stimulus and verdict for the three-axis PID controller.
module testbench;
  import tpc_pkg::*;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, drives_seen;
  int send_idle_pct, recv_stall_pct;
  int hold_off;
  int cycle_count;
  int updates_sent, clears_sent;

  three_axis_pid_controller_top DUT (.*);

  tpc_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // keep valid up between back-to-back transactions; drop it only while idling
  task automatic send_item(input logic [1:0] req, input logic ext,
                           input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= {ext, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == REQ_UPDATE) updates_sent++;
    else clears_sent++;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_payload(input bit tiny_dt);
    logic [IN_DATA_W-1:0] d;
    for (int f = 0; f < 8; f++) d[16*f +: 16] = pick16();
    d[128 +: 16] = tiny_dt ? 16'($urandom_range(3)) : 16'($urandom);
    return d;
  endfunction

  function automatic logic [47:0] rand_gains();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return {16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
  endfunction

  // stop sending, drain results, then allow any clear request to retire
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_setting(input int k);
    logic [30:0] lim;
    logic [15:0] step;
    case (k % 4)
      0: begin lim = '1; step = 16'd0; end
      1: begin lim = '0; step = 16'hffff; end
      2: begin lim = 31'($urandom); step = 16'd1; end
      default: begin lim = 31'($urandom_range(1 << 20)); step = 16'($urandom_range(5000)); end
    endcase
    write_reg(CFG_GAINS_ROLL, rand_gains());
    write_reg(CFG_GAINS_PITCH, rand_gains());
    write_reg(CFG_GAINS_YAW, rand_gains());
    write_reg(CFG_INT_LIMIT, 48'(lim));
    write_reg(CFG_FIXED_STEP, 48'(step));
  endtask

  initial begin
    logic [IN_DATA_W-1:0] d;
    logic [1:0] req;
    cycle_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    out_tready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    updates_sent = 0; clears_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme gains, full limit, elapsed step
    write_reg(CFG_GAINS_ROLL, '1);
    write_reg(CFG_GAINS_PITCH, 48'h0001_0001_0001);
    write_reg(CFG_GAINS_YAW, 48'h1000_1000_1000);
    write_reg(CFG_INT_LIMIT, 48'h7fff_ffff);
    write_reg(CFG_FIXED_STEP, 48'd0);
    send_item(REQ_UPDATE, 1'b0, {16'd0, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
    send_item(REQ_UPDATE, 1'b0, {16'hffff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                                16'h7fff, 16'h8000, 16'h8000, 16'h8000});
    send_item(REQ_UPDATE, 1'b1, {16'd1, 16'h7fff, 16'h8000, 16'h0, 16'h1234,
                                16'hfedc, 16'h0100, 16'hff00, 16'h0});
    send_item(REQ_NONE, 1'b1, '1);
    send_item(REQ_UPDATE, 1'b0, {16'd0, 112'h0, 16'h7fff});
    send_item(REQ_CLR_INT, 1'b0, '0);
    send_item(REQ_UPDATE, 1'b0, {16'd1000, 128'h0});
    send_item(REQ_CLR_ALL, 1'b1, '1);
    send_item(REQ_UPDATE, 1'b1, rand_payload(1'b0));
    settle();
    // lowered limit pulls the integrator inside
    write_reg(CFG_INT_LIMIT, 48'd256);
    write_reg(CFG_FIXED_STEP, 48'hffff);
    send_item(REQ_UPDATE, 1'b0, {16'hffff, 16'h0, 16'h0, 16'h8000,
                                16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
    send_item(REQ_UPDATE, 1'b0, rand_payload(1'b0));
    settle();

    // random phases across idling modes and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      load_setting(ph);
      if (ph == 2) hold_off = 3000;
      for (int n = 0; n < 175; n++) begin
        case ($urandom_range(19))
          0: req = REQ_CLR_INT;
          1: req = REQ_CLR_ALL;
          2: req = REQ_NONE;
          default: req = REQ_UPDATE;
        endcase
        d = rand_payload($urandom_range(7) == 0);
        send_item(req, 1'($urandom), d);
      end
      settle();
    end

    send_idle_pct = 0; recv_stall_pct = 0;
    settle();
    $display("Sent %0d updates and %0d clear or ignored requests; %0d drive results checked",
             updates_sent, clears_sent, drives_seen);
    $display("Covered gain and limit extremes, fixed and elapsed step, external rates, stalls");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
